[rtl/led_bouncing_sprite_fade_engine_defines.svh]
// ----------------------------------------------------------------------------
// LED bouncing sprite fade engine: assertion macros
// Shared concurrent assertion forms for the engine's port checker.
// ----------------------------------------------------------------------------
`ifndef LED_BOUNCING_SPRITE_FADE_ENGINE_DEFINES_SVH
`define LED_BOUNCING_SPRITE_FADE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbsf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbsf assertion failed");

`endif

[rtl/lbsf_pkg.sv]
// ----------------------------------------------------------------------------
// LED bouncing sprite fade engine package
// Word types, codes and register reset values shared by the engine's files.
// ----------------------------------------------------------------------------
package lbsf_pkg;

  localparam int POS_W     = 9;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Action codes of an input word.
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_END = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_END = 3'd4;

  // Register reset values.
  localparam logic [7:0]         DECAY_RST    = 8'd2;
  localparam logic [COLOR_W-1:0] COLOR_A_RST  = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_B_RST  = 24'h00FF00;
  localparam logic [POS_W-1:0]   LOW_END_RST  = 9'd0;
  localparam logic [POS_W-1:0]   HIGH_END_RST = 9'd511;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] pixel_index;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [POS_W-1:0]   sprite_a_place;
    logic [POS_W-1:0]   sprite_b_place;
  } out_word_t;

  // Position and direction of one sprite.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             down;
  } sprite_t;

  typedef enum logic [0:0] {
    ALU_FADE = 1'b0,
    ALU_ADD  = 1'b1
  } alu_op_t;

endpackage

[rtl/lbsf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lbsf_alu.sv]
// ----------------------------------------------------------------------------
// Pixel channel unit
// Saturating per-channel subtract (fade) or add (sprite colour) on one pixel.
// ----------------------------------------------------------------------------
module lbsf_alu (
  input  lbsf_pkg::alu_op_t                op,
  input  logic [lbsf_pkg::COLOR_W-1:0]     pixel,
  input  logic [lbsf_pkg::COLOR_W-1:0]     operand,
  output logic [lbsf_pkg::COLOR_W-1:0]     result
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] o;
    logic [8:0] s;
    result = '0;
    s      = '0;
    for (int ch = 0; ch < 3; ch++) begin
      c = pixel[ch*8 +: 8];
      o = operand[ch*8 +: 8];
      if (op == lbsf_pkg::ALU_FADE) begin
        result[ch*8 +: 8] = (c > o) ? c - o : 8'd0;
      end else begin
        s = {1'b0, c} + {1'b0, o};
        result[ch*8 +: 8] = s[8] ? lbsf_pkg::CHAN_MAX : s[7:0];
      end
    end
  end

endmodule

[rtl/lbsf_step.sv]
// ----------------------------------------------------------------------------
// Sprite step unit
// Moves a sprite one pixel and bounces it at the effective ends.
// ----------------------------------------------------------------------------
module lbsf_step (
  input  lbsf_pkg::sprite_t              cur,
  input  logic [lbsf_pkg::POS_W-1:0]     lo,
  input  logic [lbsf_pkg::POS_W-1:0]     hi,
  output lbsf_pkg::sprite_t              nxt
);

  logic signed [lbsf_pkg::POS_W+1:0] cur_s;
  logic signed [lbsf_pkg::POS_W+1:0] np_s;
  logic signed [lbsf_pkg::POS_W+1:0] lo_s;
  logic signed [lbsf_pkg::POS_W+1:0] hi_s;

  assign cur_s = $signed({2'b00, cur.pos});
  assign lo_s  = $signed({2'b00, lo});
  assign hi_s  = $signed({2'b00, hi});
  assign np_s  = cur.down ? cur_s - 11'sd1 : cur_s + 11'sd1;

  // The high end wins when both ends are hit, which covers equal ends.
  always_comb begin
    if (np_s >= hi_s) begin
      nxt.pos  = hi;
      nxt.down = ~cur.down;
    end else if (np_s <= lo_s) begin
      nxt.pos  = lo;
      nxt.down = ~cur.down;
    end else begin
      nxt.pos  = np_s[lbsf_pkg::POS_W-1:0];
      nxt.down = cur.down;
    end
  end

endmodule

[rtl/led_bouncing_sprite_fade_engine.sv]
// ----------------------------------------------------------------------------
// LED bouncing sprite fade engine
// Frame store of RGB pixels with two bouncing sprites and a per-tick fade.
// ----------------------------------------------------------------------------
// Every accepted word returns exactly one result word carrying both sprite
// positions and, for a read, the pixel colour. The frame lives in a single
// RAM with one write and one read port, and all pixel arithmetic goes through
// one saturating channel unit, so the RAM port sets the timing: a tick sweeps
// every pixel, fading each, and then moves and paints both sprites; a restart
// clears the frame; a read fetches one pixel; an unused action only returns
// the sprite positions. After reset the block runs a clearing pass over every
// pixel with in_ready low; configuration writes are taken at all times
// (cfg_ready is always high). A result word waits in an output register, and
// a new word may be accepted meanwhile.
module led_bouncing_sprite_fade_engine #(
  parameter int PIXEL_COUNT = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lbsf_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lbsf_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbsf_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int AW = $clog2(PIXEL_COUNT);
  localparam int CW = lbsf_pkg::COLOR_W;
  localparam int PW = lbsf_pkg::POS_W;

  // Highest reachable pixel: the end registers are clamped to this.
  localparam logic [PW-1:0] END_TOP =
    (PIXEL_COUNT > 512) ? 9'd511 : PW'(PIXEL_COUNT - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

  typedef enum logic [11:0] {
    S_INIT      = 12'b0000_0000_0001,
    S_IDLE      = 12'b0000_0000_0010,
    S_CLEAR     = 12'b0000_0000_0100,
    S_FADE      = 12'b0000_0000_1000,
    S_FADE_LAST = 12'b0000_0001_0000,
    S_A_RD      = 12'b0000_0010_0000,
    S_A_WR      = 12'b0000_0100_0000,
    S_B_RD      = 12'b0000_1000_0000,
    S_B_WR      = 12'b0001_0000_0000,
    S_READ      = 12'b0010_0000_0000,
    S_READ_WAIT = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [7:0]    decay_r;
  logic [CW-1:0] color_a_r;
  logic [CW-1:0] color_b_r;
  logic [PW-1:0] low_end_r;
  logic [PW-1:0] high_end_r;

  // Sprite state.
  lbsf_pkg::sprite_t spr_a_r, spr_a_nxt;
  lbsf_pkg::sprite_t spr_b_r, spr_b_nxt;

  // Sequencer state and item registers.
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic          range_r, range_nxt;
  logic [CW-1:0] color_r, color_nxt;

  logic                out_valid_r, out_valid_nxt;
  lbsf_pkg::out_word_t out_data_r, out_data_nxt;

  // Effective ends.
  logic [PW-1:0] low_c, high_c, end_lo, end_hi;

  // Shared units and RAM ports.
  lbsf_pkg::sprite_t step_cur, step_nxt;
  lbsf_pkg::alu_op_t alu_op;
  logic [CW-1:0]     alu_operand, alu_result;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CW-1:0]     ram_wdata, ram_rdata;

  logic in_fire;

  assign low_c  = (low_end_r  > END_TOP) ? END_TOP : low_end_r;
  assign high_c = (high_end_r > END_TOP) ? END_TOP : high_end_r;
  assign end_lo = (low_c < high_c) ? low_c : high_c;
  assign end_hi = (low_c < high_c) ? high_c : low_c;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r    <= lbsf_pkg::DECAY_RST;
      color_a_r  <= lbsf_pkg::COLOR_A_RST;
      color_b_r  <= lbsf_pkg::COLOR_B_RST;
      low_end_r  <= lbsf_pkg::LOW_END_RST;
      high_end_r <= lbsf_pkg::HIGH_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbsf_pkg::REG_DECAY:    decay_r    <= cfg_data[7:0];
        lbsf_pkg::REG_COLOR_A:  color_a_r  <= cfg_data[CW-1:0];
        lbsf_pkg::REG_COLOR_B:  color_b_r  <= cfg_data[CW-1:0];
        lbsf_pkg::REG_LOW_END:  low_end_r  <= cfg_data[PW-1:0];
        lbsf_pkg::REG_HIGH_END: high_end_r <= cfg_data[PW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The step unit serves sprite B only in its own read state.
  assign step_cur = (state_r == S_B_RD) ? spr_b_r : spr_a_r;

  lbsf_step u_step (
    .cur (step_cur),
    .lo  (end_lo),
    .hi  (end_hi),
    .nxt (step_nxt)
  );

  // The channel unit fades during the sweep and adds sprite colours after it.
  always_comb begin
    alu_op      = lbsf_pkg::ALU_ADD;
    alu_operand = color_a_r;
    if (state_r == S_FADE || state_r == S_FADE_LAST) begin
      alu_op      = lbsf_pkg::ALU_FADE;
      alu_operand = {decay_r, decay_r, decay_r};
    end else if (state_r == S_B_WR) begin
      alu_operand = color_b_r;
    end
  end

  lbsf_alu u_alu (
    .op      (alu_op),
    .pixel   (ram_rdata),
    .operand (alu_operand),
    .result  (alu_result)
  );

  lbsf_ram #(
    .WIDTH (CW),
    .DEPTH (PIXEL_COUNT)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer. During the fade sweep pixel cnt is read while the faded value
  // of pixel cnt-1 is written back, so the two ports never meet on one address.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    range_nxt     = range_r;
    color_nxt     = color_r;
    spr_a_nxt     = spr_a_r;
    spr_b_nxt     = spr_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = alu_result;
    ram_raddr     = cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = '0;
          color_nxt = '0;
          idx_nxt   = in_data.pixel_index;
          range_nxt = (32'(in_data.pixel_index) < PIXEL_COUNT);
          case (in_data.action)
            lbsf_pkg::ACT_RESTART: begin
              spr_a_nxt.pos  = end_lo;
              spr_a_nxt.down = 1'b0;
              spr_b_nxt.pos  = end_hi;
              spr_b_nxt.down = 1'b1;
              state_nxt      = S_CLEAR;
            end
            lbsf_pkg::ACT_TICK: state_nxt = S_FADE;
            lbsf_pkg::ACT_READ: state_nxt = S_READ;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_FADE: begin
        ram_raddr = cnt_r;
        ram_waddr = cnt_r - 1'b1;
        ram_we    = (cnt_r != '0);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_FADE_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FADE_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        state_nxt = S_A_RD;
      end
      S_A_RD: begin
        ram_raddr = AW'(step_nxt.pos);
        spr_a_nxt = step_nxt;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(spr_a_r.pos);
        state_nxt = S_B_RD;
      end
      S_B_RD: begin
        ram_raddr = AW'(step_nxt.pos);
        spr_b_nxt = step_nxt;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(spr_b_r.pos);
        state_nxt = S_DONE;
      end
      S_READ: begin
        ram_raddr = AW'(idx_r);
        state_nxt = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        color_nxt = range_r ? ram_rdata : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.pixel_color    = color_r;
          out_data_nxt.sprite_a_place = spr_a_r.pos;
          out_data_nxt.sprite_b_place = spr_b_r.pos;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Control registers. Reset leaves the sprites where a restart with the
  // reset end values would put them, and starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      spr_a_r.pos  <= lbsf_pkg::LOW_END_RST;
      spr_a_r.down <= 1'b0;
      spr_b_r.pos  <= END_TOP;
      spr_b_r.down <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      spr_a_r     <= spr_a_nxt;
      spr_b_r     <= spr_b_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    range_r    <= range_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/lbsf_checker.sv]
// ----------------------------------------------------------------------------
// LED bouncing sprite fade engine port checker
// Watches the engine's ports over time and flags handshake slips.
// ----------------------------------------------------------------------------
`include "led_bouncing_sprite_fade_engine_defines.svh"

module lbsf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lbsf_pkg::out_word_t out_data
);

  // A result word holds until it is taken.
  `LBSF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // The engine works on one word at a time: an acceptance drops ready.
  `LBSF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A new result only appears at the end of a busy stretch.
  `LBSF_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind led_bouncing_sprite_fade_engine lbsf_checker u_lbsf_checker (.*);
